// ===== design/pblm_pkg.sv =====
`default_nettype none

package pblm_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 32;
  localparam int PEAK_W     = 17;
  localparam int LVL_W      = 8;
  localparam int NUM_BANDS  = 4;
  localparam int BAND_W     = 2;

  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_BASS_SHIFT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MID_SHIFT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PEAK_FLOOR  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DECAY_SHIFT = 2'd3;

  localparam logic [3:0]  RST_BASS_SHIFT  = 4'd5;
  localparam logic [3:0]  RST_MID_SHIFT   = 4'd2;
  localparam logic [15:0] RST_PEAK_FLOOR  = 16'd256;
  localparam logic [4:0]  RST_DECAY_SHIFT = 5'd11;

  localparam logic [LVL_W-1:0] LVL_MAX = 8'd255;

endpackage

`default_nettype wire

// ===== design/pcm_band_level_meter.sv =====
// Three-band level meter for 16-bit stereo PCM.
//
// Input stream: one stereo frame per transaction; in_tlast marks the last
// frame of an analysis block. A block is also closed on its MAX_FRAMES-th
// frame. Output stream: one transaction per closed block carrying the four
// smoothed levels (bass, mid, treble, loudness), 0..255 each.
// Config: cfg_we/cfg_addr/cfg_wdata write the filter shifts, the peak floor
// and the peak decay shift; write only while the meter is idle.
//
// A frame that does not close a block passes through the accept, mono, filter
// and accumulate states; in_tready returns once the meter is idle. A closing
// frame additionally runs the shared 32-step restoring divider twice per band
// (block average, then normalization against the peak), and an output state
// then raises out_tvalid once the output register is free.
// The result sits in an output register; the next frames are accepted while
// it waits. A further closing frame waits for that register to empty, so a
// stalled receiver eventually holds off the input side.
// Reset (rst_n low, synchronous) restores default config and clears filter
// states, sums, frame count, peaks and levels.
`default_nettype none

module pcm_band_level_meter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // left_sample [15:0], right_sample [31:16]
  input  wire logic        in_tlast,   // last_frame
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // bass [7:0], mid [15:8], treble [23:16],
                                       // loudness [31:24]
  input  wire logic        cfg_we,
  input  wire logic [pblm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [pblm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_MONO, S_LP, S_SUM, S_LOAD1, S_DIV1, S_PEAK, S_DIV2, S_LEVEL, S_EMIT
  } state_t;

  typedef logic [pblm_pkg::SUM_W-1:0]  sum_t;
  typedef logic [pblm_pkg::PEAK_W-1:0] peak_t;
  typedef logic [pblm_pkg::LVL_W-1:0]  lvl_t;

  function automatic logic signed [15:0] lp_step(input logic signed [15:0] s,
                                                 input logic signed [15:0] target,
                                                 input logic [3:0] sh);
    logic signed [17:0] d;
    logic [16:0]        m;
    logic [16:0]        q;
    logic signed [17:0] r;
    d = {{2{target[15]}}, target} - {{2{s[15]}}, s};
    m = d[17] ? 17'(-d) : d[16:0];
    q = m >> sh;
    r = d[17] ? ({{2{s[15]}}, s} - {1'b0, q}) : ({{2{s[15]}}, s} + {1'b0, q});
    return r[15:0];
  endfunction

  function automatic logic [16:0] mag17(input logic signed [16:0] x);
    logic [16:0] neg;
    neg = 17'(-x);
    return x[16] ? neg : x;
  endfunction

  // control / architectural state
  state_t                          state_r, state_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [31:0]                     out_data_r, out_data_nxt;
  logic [3:0]                      bass_sh_r, bass_sh_nxt;
  logic [3:0]                      mid_sh_r, mid_sh_nxt;
  logic [15:0]                     floor_r, floor_nxt;
  logic [4:0]                      decay_sh_r, decay_sh_nxt;
  logic signed [15:0]              bass_lp_r, bass_lp_nxt;
  logic signed [15:0]              mid_lp_r, mid_lp_nxt;
  sum_t                            sum_r [pblm_pkg::NUM_BANDS];
  sum_t                            sum_nxt [pblm_pkg::NUM_BANDS];
  peak_t                           peak_r [pblm_pkg::NUM_BANDS];
  peak_t                           peak_nxt [pblm_pkg::NUM_BANDS];
  lvl_t                            lvl_r [pblm_pkg::NUM_BANDS];
  lvl_t                            lvl_nxt [pblm_pkg::NUM_BANDS];
  logic [pblm_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [pblm_pkg::BAND_W-1:0]     band_r, band_nxt;

  // datapath registers
  logic signed [15:0]              left_r, right_r, left_nxt, right_nxt;
  logic                            last_r, last_nxt;
  logic signed [15:0]              mono_r, mono_nxt;
  logic [pblm_pkg::SUM_W-1:0]      quo_r, quo_nxt;
  logic [pblm_pkg::PEAK_W-1:0]     rem_r, rem_nxt;
  logic [pblm_pkg::PEAK_W-1:0]     dvs_r, dvs_nxt;
  logic [pblm_pkg::DIV_CNT_W-1:0]  dcnt_r, dcnt_nxt;

  // combinational helpers
  logic signed [16:0]              pair_sum;
  logic [pblm_pkg::PEAK_W:0]       div_shift;
  logic [pblm_pkg::PEAK_W+1:0]     div_diff;
  logic                            div_ge;
  logic [16:0]                     m_bass, m_mid, m_treb, m_loud;
  logic [pblm_pkg::CNT_W-1:0]      cnt_inc;
  peak_t                           pk_cur, pk_step;
  lvl_t                            lvl_new;
  logic [9:0]                      smooth;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    pair_sum  = {left_r[15], left_r} + {right_r[15], right_r};
    div_shift = {rem_r, quo_r[pblm_pkg::SUM_W-1]};
    div_diff  = {1'b0, div_shift} - {2'b00, dvs_r};
    div_ge    = !div_diff[pblm_pkg::PEAK_W+1];
    m_bass    = mag17({bass_lp_r[15], bass_lp_r});
    m_mid     = mag17({mid_lp_r[15], mid_lp_r} - {bass_lp_r[15], bass_lp_r});
    m_treb    = mag17({mono_r[15], mono_r} - {mid_lp_r[15], mid_lp_r});
    m_loud    = mag17({mono_r[15], mono_r});
    cnt_inc   = cnt_r + 1'b1;
    pk_cur    = peak_r[band_r];
    pk_step   = pk_cur >> decay_sh_r;
    if (pk_step == '0) begin
      pk_step = peak_t'(1);
    end
    lvl_new = (quo_r[pblm_pkg::SUM_W-1:pblm_pkg::LVL_W] != '0) ? pblm_pkg::LVL_MAX
                                                              : quo_r[pblm_pkg::LVL_W-1:0];
    smooth  = 10'(lvl_r[band_r]) * 10'd3 + 10'(lvl_new);

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    bass_sh_nxt   = bass_sh_r;
    mid_sh_nxt    = mid_sh_r;
    floor_nxt     = floor_r;
    decay_sh_nxt  = decay_sh_r;
    bass_lp_nxt   = bass_lp_r;
    mid_lp_nxt    = mid_lp_r;
    sum_nxt       = sum_r;
    peak_nxt      = peak_r;
    lvl_nxt       = lvl_r;
    cnt_nxt       = cnt_r;
    band_nxt      = band_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    last_nxt      = last_r;
    mono_nxt      = mono_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    dcnt_nxt      = dcnt_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_addr)
        pblm_pkg::CFG_BASS_SHIFT:  bass_sh_nxt  = cfg_wdata[3:0];
        pblm_pkg::CFG_MID_SHIFT:   mid_sh_nxt   = cfg_wdata[3:0];
        pblm_pkg::CFG_PEAK_FLOOR:  floor_nxt    = cfg_wdata;
        pblm_pkg::CFG_DECAY_SHIFT: decay_sh_nxt = cfg_wdata[4:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          left_nxt  = in_tdata[15:0];
          right_nxt = in_tdata[31:16];
          last_nxt  = in_tlast;
          state_nxt = S_MONO;
        end
      end
      S_MONO: begin
        // halve, truncating toward zero
        mono_nxt  = 16'((pair_sum + 17'(pair_sum[16] & pair_sum[0])) >>> 1);
        state_nxt = S_LP;
      end
      S_LP: begin
        bass_lp_nxt = lp_step(bass_lp_r, mono_r, bass_sh_r);
        mid_lp_nxt  = lp_step(mid_lp_r, mono_r, mid_sh_r);
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        sum_nxt[0] = sum_r[0] + sum_t'(m_bass);
        sum_nxt[1] = sum_r[1] + sum_t'(m_mid);
        sum_nxt[2] = sum_r[2] + sum_t'(m_treb);
        sum_nxt[3] = sum_r[3] + sum_t'(m_loud);
        cnt_nxt    = cnt_inc;
        band_nxt   = '0;
        if (last_r || (cnt_inc >= pblm_pkg::CNT_W'(pblm_pkg::MAX_FRAMES))) begin
          state_nxt = S_LOAD1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LOAD1: begin
        quo_nxt   = sum_r[band_r];
        rem_nxt   = '0;
        dvs_nxt   = pblm_pkg::PEAK_W'(cnt_r);
        dcnt_nxt  = '0;
        state_nxt = S_DIV1;
      end
      S_DIV1, S_DIV2: begin
        rem_nxt  = div_ge ? div_diff[pblm_pkg::PEAK_W-1:0] : div_shift[pblm_pkg::PEAK_W-1:0];
        quo_nxt  = {quo_r[pblm_pkg::SUM_W-2:0], div_ge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == pblm_pkg::DIV_CNT_W'(pblm_pkg::DIV_STEPS - 1)) begin
          state_nxt = (state_r == S_DIV1) ? S_PEAK : S_LEVEL;
        end
      end
      S_PEAK: begin
        // block average is in quo_r; peak update and value*255 both use it here
        state_nxt = S_DIV2;
        dcnt_nxt  = '0;
        rem_nxt   = '0;
        if ({1'b0, quo_r[15:0]} > pk_cur) begin
          peak_nxt[band_r] = {1'b0, quo_r[15:0]};
        end else if (pk_cur > {1'b0, floor_r}) begin
          peak_nxt[band_r] = pk_cur - pk_step;
        end else begin
          peak_nxt[band_r] = pk_cur;
        end
        quo_nxt = pblm_pkg::SUM_W'({quo_r[15:0], 8'd0} - {8'd0, quo_r[15:0]});
        dvs_nxt = (peak_nxt[band_r] == '0) ? peak_t'(1) : peak_nxt[band_r];
      end
      S_LEVEL: begin
        lvl_nxt[band_r] = smooth[9:2];
        sum_nxt[band_r] = '0;
        band_nxt        = band_r + 1'b1;
        if (band_r == pblm_pkg::BAND_W'(pblm_pkg::NUM_BANDS - 1)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_LOAD1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {lvl_r[3], lvl_r[2], lvl_r[1], lvl_r[0]};
          cnt_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      bass_sh_r   <= pblm_pkg::RST_BASS_SHIFT;
      mid_sh_r    <= pblm_pkg::RST_MID_SHIFT;
      floor_r     <= pblm_pkg::RST_PEAK_FLOOR;
      decay_sh_r  <= pblm_pkg::RST_DECAY_SHIFT;
      bass_lp_r   <= '0;
      mid_lp_r    <= '0;
      cnt_r       <= '0;
      band_r      <= '0;
      for (int i = 0; i < pblm_pkg::NUM_BANDS; i++) begin
        sum_r[i]  <= '0;
        peak_r[i] <= '0;
        lvl_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      bass_sh_r   <= bass_sh_nxt;
      mid_sh_r    <= mid_sh_nxt;
      floor_r     <= floor_nxt;
      decay_sh_r  <= decay_sh_nxt;
      bass_lp_r   <= bass_lp_nxt;
      mid_lp_r    <= mid_lp_nxt;
      cnt_r       <= cnt_nxt;
      band_r      <= band_nxt;
      sum_r       <= sum_nxt;
      peak_r      <= peak_nxt;
      lvl_r       <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
    last_r  <= last_nxt;
    mono_r  <= mono_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    dcnt_r  <= dcnt_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pblm_pkg::CNT_W'(pblm_pkg::MAX_FRAMES))
    else $error("frame count beyond block limit");

  a_avg_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PEAK |-> quo_r[pblm_pkg::SUM_W-1:16] == '0)
    else $error("block average wider than 16 bits");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LEVEL |-> rem_r < dvs_r)
    else $error("divider remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 || state_r == S_DIV2) |-> dvs_r != '0)
    else $error("divider started with zero divisor");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_tready)) |=> out_valid_r && cnt_r == '0)
    else $error("block result not presented");

endmodule

`default_nettype wire
